@@ src/fbsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fbsa_pkg;

  // Field widths of the request and response transactions.
  localparam int unsigned SIZE_W   = 23;
  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned QUO_W    = 24;
  localparam int unsigned START_W  = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned WB_W     = 7;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned ENTRY_W  = START_W + LEN_W + 1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FIT_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WORD_BYTES = 2'd1;
  localparam logic [CIDX_W-1:0] REG_POOL_WORDS = 2'd2;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZERO      = 3'd4;

  // Request opcodes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic scan;
    logic decide;
    logic sh_rd;
    logic sh_wr;
    logic wr_split;
    logic wr_pick;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_in;
    logic div_last;
    logic scan_done;
    logic need_split;
    logic do_write;
    logic sh_done;
    logic out_ready;
  } sts_t;

endpackage
`default_nettype wire

@@ src/fbsa_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fbsa_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/fbsa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fbsa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire fbsa_pkg::sts_t sts_i,
  output fbsa_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SCAN, S_DECIDE, S_SH_CHK, S_SH_RD, S_SH_WR,
    S_SPLIT, S_PICK, S_DONE
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.zero_in ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.need_split) state_d = S_SH_CHK;
        else if (sts_i.do_write) state_d = S_PICK;
        else state_d = S_DONE;
      end
      S_SH_CHK: begin
        state_d = sts_i.sh_done ? S_SPLIT : S_SH_RD;
      end
      S_SH_RD: begin
        cmd_o.sh_rd = 1'b1;
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d = S_SH_CHK;
      end
      S_SPLIT: begin
        cmd_o.wr_split = 1'b1;
        state_d = S_PICK;
      end
      S_PICK: begin
        cmd_o.wr_pick = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_ready) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ src/fbsa_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fbsa_dpath #(
  parameter int unsigned MAX_SEGMENTS   = 64,
  parameter int unsigned MAX_POOL_WORDS = 65536
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [fbsa_pkg::CIDX_W-1:0]       cfg_idx_i,
  input  wire logic [fbsa_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                              func_i,
  input  wire logic [fbsa_pkg::SIZE_W-1:0]       size_bytes_i,
  input  wire logic [fbsa_pkg::ADDR_W-1:0]       byte_address_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [fbsa_pkg::STAT_W-1:0]       status_o,
  output logic      [fbsa_pkg::ADDR_W-1:0]       byte_offset_o,
  input  wire fbsa_pkg::cmd_t                    cmd_i,
  output fbsa_pkg::sts_t                         sts_o
);

  localparam int unsigned SW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned QW = fbsa_pkg::QUO_W;
  localparam int unsigned LW = fbsa_pkg::LEN_W;
  localparam int unsigned TW = fbsa_pkg::START_W;
  localparam int unsigned WW = fbsa_pkg::WB_W;
  localparam logic [LW-1:0] MAX_POOL = LW'(MAX_POOL_WORDS);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_SEGMENTS);

  // Configuration registers.
  logic          fit_mode_q;
  logic [WW-1:0] word_bytes_q;
  logic [LW-1:0] pool_q;
  logic          pool_wr;

  assign pool_wr = cfg_we_i && (cfg_idx_i == fbsa_pkg::REG_POOL_WORDS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= 1'b0;
      word_bytes_q <= WW'(8);
      pool_q       <= LW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbsa_pkg::REG_FIT_MODE:   fit_mode_q   <= cfg_data_i[0];
        fbsa_pkg::REG_WORD_BYTES: word_bytes_q <= cfg_data_i[WW-1:0];
        fbsa_pkg::REG_POOL_WORDS: pool_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped word size and pool size.
  logic [WW-1:0] eff_w;
  logic [LW-1:0] eff_pool;
  always_comb begin
    if (word_bytes_q == '0) eff_w = WW'(1);
    else if (word_bytes_q > WW'(64)) eff_w = WW'(64);
    else eff_w = word_bytes_q;
    if (pool_q == '0) eff_pool = LW'(1);
    else if (pool_q > MAX_POOL) eff_pool = MAX_POOL;
    else eff_pool = pool_q;
  end

  // Request registers and the bit-serial divider.
  logic          func_q;
  logic [QW-1:0] quo_q, quo_d;
  logic [WW-1:0] prem_q, prem_d;
  logic [4:0]    dcnt_q;
  logic [WW:0]   dtrial;
  logic          dge;
  logic [QW-1:0] dividend;

  assign dividend = (func_i == fbsa_pkg::FUNC_FREE) ? QW'(byte_address_i)
                  : QW'(size_bytes_i) + QW'(eff_w) - QW'(1);
  assign dtrial   = {prem_q, quo_q[QW-1]};
  assign dge      = (dtrial >= {1'b0, eff_w});
  assign prem_d   = dge ? WW'(dtrial - {1'b0, eff_w}) : dtrial[WW-1:0];
  assign quo_d    = {quo_q[QW-2:0], dge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      quo_q  <= dividend;
      prem_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= quo_d;
      prem_q <= prem_d;
      dcnt_q <= dcnt_q + 5'd1;
    end
  end

  // Segment table storage.
  logic [fbsa_pkg::ENTRY_W-1:0] rdata, wdata;
  logic [SW-1:0]                raddr, waddr;
  logic                         we;

  fbsa_ram #(.WIDTH(fbsa_pkg::ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entry 0 reads as the whole pool until it is first written after reset or a pool-size write.
  logic fresh_q, fresh_rd_q;
  logic [CW-1:0] count_q, scan_idx_q, sh_idx_q;
  logic [SW-1:0] ev_idx_q, pick_q;
  logic          ev_valid_q, issue;

  assign issue = cmd_i.scan && (scan_idx_q < count_q);
  assign raddr = cmd_i.sh_rd ? SW'(sh_idx_q - CW'(1)) : scan_idx_q[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else if (pool_wr) begin
      fresh_q <= 1'b1;
    end else if (we && (waddr == '0)) begin
      fresh_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    fresh_rd_q <= fresh_q && (raddr == '0);
  end

  logic [TW-1:0] e_start;
  logic [LW-1:0] e_len;
  logic          e_used;
  always_comb begin
    if (fresh_rd_q) begin
      e_start = '0;
      e_len   = eff_pool;
      e_used  = 1'b0;
    end else begin
      {e_start, e_len, e_used} = rdata;
    end
  end

  // Scan evaluation: fit search for allocate, start match for free.
  logic          found_q, split_q;
  logic [TW-1:0] pick_start_q;
  logic [LW-1:0] pick_len_q, best_rem_q;
  logic [LW-1:0] e_rem;
  logic          cand, better;

  assign e_rem = e_len - quo_q[LW-1:0];
  always_comb begin
    if (func_q == fbsa_pkg::FUNC_FREE) begin
      cand   = e_used && (QW'(e_start) == quo_q);
      better = !found_q;
    end else begin
      cand   = !e_used && (QW'(e_len) >= quo_q);
      better = !found_q || (fit_mode_q ? (e_rem > best_rem_q) : (e_rem < best_rem_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else begin
      ev_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      scan_idx_q <= '0;
      found_q    <= 1'b0;
    end else begin
      if (issue) begin
        scan_idx_q <= scan_idx_q + CW'(1);
        ev_idx_q   <= scan_idx_q[SW-1:0];
      end
      if (ev_valid_q && cand && better) begin
        found_q      <= 1'b1;
        pick_q       <= ev_idx_q;
        pick_start_q <= e_start;
        pick_len_q   <= e_len;
        best_rem_q   <= e_rem;
      end
    end
  end

  // Decision flags.
  logic rem_nz, full, alloc;
  assign alloc  = (func_q == fbsa_pkg::FUNC_ALLOC);
  assign rem_nz = (best_rem_q != '0);
  assign full   = (count_q == MAX_CNT);

  logic [fbsa_pkg::STAT_W-1:0] res_status_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_status_q <= fbsa_pkg::ST_ZERO;
    end else if (cmd_i.decide) begin
      if (!alloc) res_status_q <= found_q ? fbsa_pkg::ST_OK : fbsa_pkg::ST_NOT_FOUND;
      else if (!found_q) res_status_q <= fbsa_pkg::ST_NO_FIT;
      else if (rem_nz && full) res_status_q <= fbsa_pkg::ST_FULL;
      else res_status_q <= fbsa_pkg::ST_OK;
      split_q  <= alloc && rem_nz;
    end
  end

  // Shift pointer walks down from the table end to the split point.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      sh_idx_q <= count_q;
    end else if (cmd_i.sh_wr) begin
      sh_idx_q <= sh_idx_q - CW'(1);
    end
  end

  // Table writes.
  always_comb begin
    we    = 1'b0;
    waddr = pick_q;
    wdata = {pick_start_q, pick_len_q, 1'b0};
    if (cmd_i.sh_wr) begin
      we    = 1'b1;
      waddr = sh_idx_q[SW-1:0];
      wdata = rdata;
    end else if (cmd_i.wr_split) begin
      we    = 1'b1;
      waddr = pick_q + SW'(1);
      wdata = {TW'(pick_start_q + quo_q[TW-1:0]), best_rem_q, 1'b0};
    end else if (cmd_i.wr_pick) begin
      we    = 1'b1;
      wdata = {pick_start_q, split_q ? quo_q[LW-1:0] : pick_len_q, alloc};
    end
  end

  // Segment count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1);
    end else if (pool_wr) begin
      count_q <= CW'(1);
    end else if (cmd_i.wr_pick && split_q) begin
      count_q <= count_q + CW'(1);
    end
  end

  // Response register.
  logic out_valid_q;
  logic [TW+WW-1:0] prod;
  assign prod = (TW+WW)'(pick_start_q) * (TW+WW)'(eff_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= res_status_q;
      byte_offset_o <= (alloc && res_status_q == fbsa_pkg::ST_OK)
                       ? prod[fbsa_pkg::ADDR_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  assign sts_o.zero_in    = (func_i == fbsa_pkg::FUNC_ALLOC) && (size_bytes_i == '0);
  assign sts_o.div_last   = (dcnt_q == 5'(QW - 1));
  assign sts_o.scan_done  = (scan_idx_q == count_q) && !ev_valid_q;
  assign sts_o.need_split = alloc && found_q && rem_nz && !full;
  assign sts_o.do_write   = found_q && !(alloc && rem_nz && full);
  assign sts_o.sh_done    = (sh_idx_q == CW'(pick_q) + CW'(1));
  assign sts_o.out_ready  = !out_valid_q || !out_stall_i;

  // The table never holds more segments than its capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= MAX_CNT))
    else $error("segment count out of range");

  // A split is never written into a full table.
  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_split |-> (count_q < MAX_CNT))
    else $error("split into full table");

  // Evaluated entries always lie inside the valid part of the table.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_valid_q |-> (CW'(ev_idx_q) < count_q))
    else $error("scan past table end");

endmodule
`default_nettype wire

@@ src/fit_based_segment_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sequence from acceptance to result: a bit-serial divide, a scan of the N table segments,
// decide, table write and output load; a failed request skips the write. A split
// also shifts each table entry above the chosen segment up by one, then writes the
// split-off remainder. A zero-size allocate goes straight from acceptance to the output load.
// Transactions are handled one at a time; the next is accepted the cycle after the result loads.
// Reset clears the table to one hole covering the pool, with no clearing pass.
module fit_based_segment_allocator_core #(
  parameter int unsigned MAX_SEGMENTS   = 64,
  parameter int unsigned MAX_POOL_WORDS = 65536
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fbsa_pkg::CIDX_W-1:0]      cfg_idx_i,
  input  wire logic [fbsa_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             func_i,
  input  wire logic [fbsa_pkg::SIZE_W-1:0]      size_bytes_i,
  input  wire logic [fbsa_pkg::ADDR_W-1:0]      byte_address_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [fbsa_pkg::STAT_W-1:0]      status_o,
  output logic      [fbsa_pkg::ADDR_W-1:0]      byte_offset_o
);

  fbsa_pkg::cmd_t cmd;
  fbsa_pkg::sts_t sts;

  // Sequencer.
  fbsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Divider, segment table and response register.
  fbsa_dpath #(
    .MAX_SEGMENTS   (MAX_SEGMENTS),
    .MAX_POOL_WORDS (MAX_POOL_WORDS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .size_bytes_i   (size_bytes_i),
    .byte_address_i (byte_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .byte_offset_o  (byte_offset_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_fit_based_segment_allocator_core.sv @@
`timescale 1ns / 1ps
module tb_fit_based_segment_allocator_core;

  localparam int NSEG = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 680;

  typedef struct {
    logic [fbsa_pkg::STAT_W-1:0] status;
    logic [fbsa_pkg::ADDR_W-1:0] offset;
  } alloc_resp_t;

  // One directed step: a register write or a request with an optional typed answer.
  typedef struct {
    bit                          is_cfg;
    logic [fbsa_pkg::CIDX_W-1:0] reg_idx;
    logic [fbsa_pkg::CFG_W-1:0]  reg_val;
    logic                        func;
    logic [fbsa_pkg::SIZE_W-1:0] size;
    logic [fbsa_pkg::ADDR_W-1:0] addr;
    bit                          typed;
    logic [fbsa_pkg::STAT_W-1:0] st;
    logic [fbsa_pkg::ADDR_W-1:0] off;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fbsa_pkg::CIDX_W-1:0] cfg_idx_i = '0;
  logic [fbsa_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic func_i = fbsa_pkg::FUNC_ALLOC;
  logic [fbsa_pkg::SIZE_W-1:0] size_bytes_i = '0;
  logic [fbsa_pkg::ADDR_W-1:0] byte_address_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic [fbsa_pkg::STAT_W-1:0] status_o;
  logic [fbsa_pkg::ADDR_W-1:0] byte_offset_o;

  fit_based_segment_allocator_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the allocator state and registers.
  logic                       fit_worst;
  logic [fbsa_pkg::WB_W-1:0]  word_reg;
  logic [fbsa_pkg::CFG_W-1:0] pool_reg;
  logic [15:0]                seg_first[NSEG];
  logic [16:0]                seg_len[NSEG];
  bit                         seg_busy[NSEG];
  int                         seg_total;

  alloc_resp_t pending_resp[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_req = 0;

  function automatic int unsigned cur_word_bytes();
    if (word_reg == 0) return 1;
    if (word_reg > 64) return 64;
    return word_reg;
  endfunction

  function automatic void table_clear();
    int unsigned p;
    p = (pool_reg == 0) ? 1 : (pool_reg > 65536) ? 65536 : pool_reg;
    for (int k = 0; k < NSEG; k++) begin
      seg_first[k] = '0;
      seg_len[k] = '0;
      seg_busy[k] = 0;
    end
    seg_len[0] = 17'(p);
    seg_total = 1;
  endfunction

  function automatic void reg_apply(logic [fbsa_pkg::CIDX_W-1:0] idx,
                                    logic [fbsa_pkg::CFG_W-1:0] val);
    case (idx)
      fbsa_pkg::REG_FIT_MODE: fit_worst = val[0];
      fbsa_pkg::REG_WORD_BYTES: word_reg = val[fbsa_pkg::WB_W-1:0];
      fbsa_pkg::REG_POOL_WORDS: begin
        pool_reg = val;
        table_clear();
      end
      default: ;
    endcase
  endfunction

  // Computes the answer to one request and updates the shadow table.
  function automatic alloc_resp_t place_or_release(logic f, logic [fbsa_pkg::SIZE_W-1:0] sz,
                                                   logic [fbsa_pkg::ADDR_W-1:0] ad);
    alloc_resp_t r;
    int unsigned w, need, rem, best, pos;
    int pick;
    bit found;
    r.status = fbsa_pkg::ST_OK;
    r.offset = '0;
    w = cur_word_bytes();
    pick = 0;
    best = 0;
    found = 0;
    if (f == fbsa_pkg::FUNC_FREE) begin
      pos = ad / w;
      r.status = fbsa_pkg::ST_NOT_FOUND;
      for (int k = 0; k < seg_total; k++) begin
        if (seg_first[k] == pos && seg_busy[k]) begin
          seg_busy[k] = 0;
          r.status = fbsa_pkg::ST_OK;
          break;
        end
      end
      return r;
    end
    if (sz == 0) begin
      r.status = fbsa_pkg::ST_ZERO;
      return r;
    end
    need = (sz + w - 1) / w;
    for (int k = 0; k < seg_total; k++) begin
      if (!seg_busy[k] && seg_len[k] >= need) begin
        rem = seg_len[k] - need;
        if (!found || (fit_worst ? rem > best : rem < best)) begin
          found = 1;
          pick = k;
          best = rem;
        end
      end
    end
    if (!found) begin
      r.status = fbsa_pkg::ST_NO_FIT;
      return r;
    end
    if (best != 0) begin
      if (seg_total >= NSEG) begin
        r.status = fbsa_pkg::ST_FULL;
        return r;
      end
      for (int k = seg_total; k > pick + 1; k--) begin
        seg_first[k] = seg_first[k-1];
        seg_len[k] = seg_len[k-1];
        seg_busy[k] = seg_busy[k-1];
      end
      seg_first[pick+1] = seg_first[pick] + need[15:0];
      seg_len[pick+1] = 17'(best);
      seg_busy[pick+1] = 0;
      seg_len[pick] = 17'(need);
      seg_total++;
    end
    seg_busy[pick] = 1;
    r.offset = 22'(seg_first[pick] * w);
    return r;
  endfunction

  // Register writes happen only with no transaction in flight.
  task automatic cfg_write(logic [fbsa_pkg::CIDX_W-1:0] idx, logic [fbsa_pkg::CFG_W-1:0] val);
    in_valid_i <= 1'b0;
    wait (pending_resp.size() == 0);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_apply(idx, val);
  endtask

  // Offers one request and waits until it is accepted.
  task automatic send_req(logic f, logic [fbsa_pkg::SIZE_W-1:0] sz,
                          logic [fbsa_pkg::ADDR_W-1:0] ad,
                          bit typed, alloc_resp_t typed_resp);
    alloc_resp_t r;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    size_bytes_i <= sz;
    byte_address_i <= ad;
    do @(posedge clk_i); while (in_stall_o);
    r = place_or_release(f, sz, ad);
    if (typed) r = typed_resp;
    pending_resp = {pending_resp, r};
  endtask

  step_t steps[] = '{
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd0, 22'd0, 1, fbsa_pkg::ST_ZERO, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd8, 22'd0, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd1, 22'd0, 1, fbsa_pkg::ST_OK, 22'd8},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'h400000, 22'd0, 1, fbsa_pkg::ST_NO_FIT, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'h7FFFFF, 22'd0, 1, fbsa_pkg::ST_NO_FIT, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_FREE, 23'h7FFFFF, 22'd0, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_FREE, 23'd0, 22'd0, 1, fbsa_pkg::ST_NOT_FOUND, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_FREE, 23'd0, 22'h3FFFFF, 1, fbsa_pkg::ST_NOT_FOUND, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_FREE, 23'd0, 22'd15, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd5, 22'd0, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd24, 22'd0, 0, fbsa_pkg::ST_OK, 22'd0},
    '{1, fbsa_pkg::REG_FIT_MODE, 17'd1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd8, 22'd0, 0, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_FREE, 23'd0, 22'd16, 0, fbsa_pkg::ST_OK, 22'd0},
    '{1, fbsa_pkg::REG_WORD_BYTES, 17'd0, 0, 0, 0, 0, 0, 0},
    '{1, fbsa_pkg::REG_POOL_WORDS, 17'd0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd1, 22'd0, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd1, 22'd0, 1, fbsa_pkg::ST_NO_FIT, 22'd0},
    '{1, fbsa_pkg::REG_WORD_BYTES, 17'd127, 0, 0, 0, 0, 0, 0},
    '{1, fbsa_pkg::REG_POOL_WORDS, 17'h1FFFF, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'h400000, 22'd0, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd1, 22'd0, 1, fbsa_pkg::ST_NO_FIT, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_FREE, 23'd0, 22'd63, 1, fbsa_pkg::ST_OK, 22'd0},
    '{0, 0, 0, fbsa_pkg::FUNC_ALLOC, 23'd100, 22'd0, 0, fbsa_pkg::ST_OK, 22'd0}
  };

  // Stimulus: the directed steps, then random phases on small and large pools.
  initial begin
    alloc_resp_t typed_resp;
    logic [fbsa_pkg::SIZE_W-1:0] sz;
    logic [fbsa_pkg::ADDR_W-1:0] ad;
    int unsigned w, p, live, pick_idx;
    fit_worst = 1'b0;
    word_reg = 8;
    pool_reg = 65536;
    table_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        cfg_write(steps[i].reg_idx, steps[i].reg_val);
      end else begin
        typed_resp.status = steps[i].st;
        typed_resp.offset = steps[i].off;
        send_req(steps[i].func, steps[i].size, steps[i].addr, steps[i].typed, typed_resp);
      end
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 70 == 0) begin
        cfg_write(fbsa_pkg::REG_FIT_MODE, 17'($urandom_range(1)));
        cfg_write(fbsa_pkg::REG_WORD_BYTES, $urandom_range(5) == 0 ? 17'($urandom_range(127))
                                                  : 17'($urandom_range(1, 64)));
        cfg_write(fbsa_pkg::REG_POOL_WORDS, $urandom_range(4) == 0
                                            ? 17'($urandom_range(17'h1FFFF))
                                            : 17'($urandom_range(40, 300)));
      end
      if (n == 250) hold_req = 1;
      if (n == 450) begin
        in_valid_i <= 1'b0;
        wait (pending_resp.size() == 0);
      end
      if (n == 560) quiet = 1;
      w = cur_word_bytes();
      p = (pool_reg == 0) ? 1 : (pool_reg > 65536) ? 65536 : pool_reg;
      sz = 23'($urandom_range(23'h7FFFFF));
      ad = 22'($urandom_range(22'h3FFFFF));
      live = 0;
      for (int k = 0; k < seg_total; k++) if (seg_busy[k]) live++;
      if ($urandom_range(9) < 6) begin
        // Mostly allocations sized against the pool, so tables fill and split.
        if ($urandom_range(19) == 0) sz = 0;
        else if ($urandom_range(9) != 0)
          sz = 23'($urandom_range(1, (p / ($urandom_range(1) ? 4 : 24) + 1) * w));
        typed_resp = '{default: '0};
        send_req(fbsa_pkg::FUNC_ALLOC, sz, ad, 0, typed_resp);
      end else begin
        if (live != 0 && $urandom_range(4) != 0) begin
          pick_idx = $urandom_range(live - 1);
          for (int k = 0; k < seg_total; k++) begin
            if (seg_busy[k]) begin
              if (pick_idx == 0) ad = 22'(seg_first[k] * w + $urandom_range(w - 1));
              pick_idx--;
            end
          end
        end
        typed_resp = '{default: '0};
        send_req(fbsa_pkg::FUNC_FREE, sz, ad, 0, typed_resp);
      end
    end
    in_valid_i <= 1'b0;
    wait (pending_resp.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: checks each transaction and stalls in random bursts.
  initial begin
    alloc_resp_t exp_r;
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_resp.size() == 0) begin
          $display("%0t: unexpected result status=%0d offset=%0d", $time, status_o,
                   byte_offset_o);
          errors++;
        end else begin
          exp_r = pending_resp.pop_front();
          if (status_o !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
            errors++;
          end
          if (byte_offset_o !== exp_r.offset) begin
            $display("%0t: byte_offset expected %0d actual %0d", $time, exp_r.offset,
                     byte_offset_o);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
